// ===== hw/rtl/tcw_pkg.sv =====
// Package for the text console writer: item kinds, character codes,
// sequencer states and default screen geometry. No dependencies.
package tcw_pkg;

    localparam int ROWS_DEF = 25;
    localparam int COLS_DEF = 80;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] BLANK_CODE   = 8'd0;

    typedef enum logic [1:0] {
        KIND_PUT   = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUT_CHK,
        ST_PUT_WR,
        ST_NL_FILL,
        ST_POST,
        ST_SCR_COPY,
        ST_SCR_DRAIN,
        ST_SCR_ZERO,
        ST_SCR_END,
        ST_CLR,
        ST_RD_ISSUE,
        ST_RD_DATA,
        ST_DONE
    } tcw_state_t;

endpackage

// ===== hw/rtl/text_console_writer.sv =====
// Items are served one at a time, with one store access per cycle in the screen
// walks; the next item is taken once the result sits in the output register.
// After rst_n, a clearing pass zeroes the store; no item is accepted during it.
// Cursor and line count reset to zero.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  code,
    input  logic [4:0]  row,
    input  logic [6:0]  col,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  cell_code,
    output logic [10:0] cursor_cell,
    output logic [4:0]  line_count
);

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS + 1);
    localparam int MAW   = $clog2(CELLS);
    localparam int LW    = $clog2(ROWS + 1);

    logic           mem_we;
    logic [MAW-1:0] mem_waddr;
    logic [7:0]     mem_wdata;
    logic [MAW-1:0] mem_raddr;
    logic [7:0]     mem_rdata;
    logic           res_valid;
    logic           res_take;
    logic [7:0]     res_cell;
    logic [AW-1:0]  res_cursor;
    logic [LW-1:0]  res_lines;

    logic           out_valid_reg, out_valid_next;
    logic [7:0]     cell_code_reg, cell_code_next;
    logic [10:0]    cursor_cell_reg, cursor_cell_next;
    logic [4:0]     line_count_reg, line_count_next;

    tcw_seq #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .code       (code),
        .row        (row),
        .col        (col),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res_cell   (res_cell),
        .res_cursor (res_cursor),
        .res_lines  (res_lines)
    );

    tcw_screen_mem #(
        .DEPTH (CELLS),
        .AW    (MAW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The output register takes a finished result when it is empty or
    // its current item leaves in the same cycle.
    assign res_take = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next   = out_valid_reg && !out_ready;
        cell_code_next   = cell_code_reg;
        cursor_cell_next = cursor_cell_reg;
        line_count_next  = line_count_reg;
        if (res_valid && res_take)
        begin
            out_valid_next   = 1'b1;
            cell_code_next   = res_cell;
            cursor_cell_next = 11'(res_cursor);
            line_count_next  = 5'(res_lines);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_code_reg   <= cell_code_next;
        cursor_cell_reg <= cursor_cell_next;
        line_count_reg  <= line_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign cell_code   = cell_code_reg;
    assign cursor_cell = cursor_cell_reg;
    assign line_count  = line_count_reg;

endmodule

// ===== hw/rtl/tcw_screen_mem.sv =====
// Character store of the text console writer: one write port and one
// registered read port. Depends on nothing but its parameters.
module tcw_screen_mem #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tcw_seq.sv =====
// Sequencer of the text console writer: cursor, line count and the
// cell-at-a-time walks for fill, scroll, clear and reset clearing.
// Depends on tcw_pkg; drives the ports of tcw_screen_mem.
module tcw_seq
    import tcw_pkg::*;
#(
    parameter int ROWS  = ROWS_DEF,
    parameter int COLS  = COLS_DEF,
    parameter int CELLS = ROWS * COLS,
    parameter int AW    = $clog2(CELLS + 1),
    parameter int MAW   = $clog2(CELLS),
    parameter int LW    = $clog2(ROWS + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     kind,
    input  logic [7:0]     code,
    input  logic [4:0]     row,
    input  logic [6:0]     col,
    output logic           mem_we,
    output logic [MAW-1:0] mem_waddr,
    output logic [7:0]     mem_wdata,
    output logic [MAW-1:0] mem_raddr,
    input  logic [7:0]     mem_rdata,
    output logic           res_valid,
    input  logic           res_take,
    output logic [7:0]     res_cell,
    output logic [AW-1:0]  res_cursor,
    output logic [LW-1:0]  res_lines
);

    localparam int CW = $clog2(COLS);

    tcw_state_t     state_reg, state_next;
    logic [7:0]     code_reg, code_next;
    logic [MAW-1:0] rd_addr_reg, rd_addr_next;
    logic           rd_ok_reg, rd_ok_next;
    logic [MAW-1:0] ptr_reg, ptr_next;
    logic           post_reg, post_next;
    logic           pend_reg, pend_next;
    logic [MAW-1:0] pend_addr_reg, pend_addr_next;
    logic [7:0]     cell_reg, cell_next;
    logic [AW-1:0]  pos_reg, pos_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [LW-1:0]  lines_reg, lines_next;

    // Shared address adder: source address during a scroll copy, cursor
    // step on writes, and cursor minus one row at the end of a scroll.
    logic [AW-1:0]  alu_a, alu_b, alu_sum;

    logic           accept;
    logic           full;
    logic           last_col;
    logic           ptr_last;
    logic           copy_last;
    logic           pos_in;
    logic [15:0]    rd_lin;

    assign accept    = in_valid && in_ready;
    assign full      = lines_reg >= LW'(ROWS);
    assign last_col  = col_reg == CW'(COLS - 1);
    assign ptr_last  = ptr_reg == MAW'(CELLS - 1);
    assign copy_last = ptr_reg == MAW'(CELLS - COLS - 1);
    assign pos_in    = pos_reg < AW'(CELLS);
    assign rd_lin    = 16'(row) * 16'(COLS) + 16'(col);

    always_comb
    begin
        alu_a = pos_reg;
        alu_b = AW'(1);
        case (state_reg)
            ST_SCR_COPY:
            begin
                alu_a = AW'(ptr_reg);
                alu_b = AW'(COLS);
            end
            ST_SCR_END:
            begin
                alu_a = pos_reg;
                alu_b = ~AW'(COLS) + AW'(1);
            end
            default:
            begin
                alu_a = pos_reg;
                alu_b = AW'(1);
            end
        endcase
        alu_sum = alu_a + alu_b;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
                if (ptr_last) state_next = ST_IDLE;
            ST_IDLE:
                if (accept)
                begin
                    case (kind)
                        KIND_PUT:   state_next = ST_PUT_CHK;
                        KIND_READ:  state_next = ST_RD_ISSUE;
                        KIND_CLEAR: state_next = ST_CLR;
                        default:    state_next = ST_DONE;
                    endcase
                end
            ST_PUT_CHK:
                if (full)
                    state_next = ST_SCR_COPY;
                else if (code_reg == NEWLINE_CODE)
                    state_next = ST_NL_FILL;
                else
                    state_next = ST_PUT_WR;
            ST_PUT_WR:
                state_next = ST_POST;
            ST_NL_FILL:
                if (last_col) state_next = ST_DONE;
            ST_POST:
                state_next = full ? ST_SCR_COPY : ST_DONE;
            ST_SCR_COPY:
                if (copy_last) state_next = ST_SCR_DRAIN;
            ST_SCR_DRAIN:
                state_next = ST_SCR_ZERO;
            ST_SCR_ZERO:
                if (ptr_last) state_next = ST_SCR_END;
            ST_SCR_END:
                state_next = post_reg ? ST_POST : ST_PUT_CHK;
            ST_CLR:
                if (ptr_last) state_next = ST_DONE;
            ST_RD_ISSUE:
                state_next = ST_RD_DATA;
            ST_RD_DATA:
                state_next = ST_DONE;
            ST_DONE:
                if (res_take) state_next = ST_IDLE;
            default:
                state_next = ST_INIT;
        endcase
    end

    // Outputs and memory ports.
    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = BLANK_CODE;
        mem_raddr = ptr_reg;
        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = BLANK_CODE;
            end
            ST_IDLE:
                in_ready = 1'b1;
            ST_PUT_WR:
            begin
                mem_we    = pos_in;
                mem_waddr = pos_reg[MAW-1:0];
                mem_wdata = code_reg;
            end
            ST_NL_FILL:
            begin
                mem_we    = pos_in;
                mem_waddr = pos_reg[MAW-1:0];
                mem_wdata = SPACE_CODE;
            end
            ST_SCR_COPY, ST_SCR_DRAIN:
            begin
                mem_raddr = alu_sum[MAW-1:0];
                mem_we    = pend_reg;
                mem_waddr = pend_addr_reg;
                mem_wdata = mem_rdata;
            end
            ST_SCR_ZERO:
            begin
                mem_we    = 1'b1;
                mem_wdata = BLANK_CODE;
            end
            ST_CLR:
            begin
                mem_we    = 1'b1;
                mem_wdata = SPACE_CODE;
            end
            ST_RD_ISSUE:
                mem_raddr = rd_addr_reg;
            ST_DONE:
                res_valid = 1'b1;
            default:
                in_ready = 1'b0;
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        code_next      = code_reg;
        rd_addr_next   = rd_addr_reg;
        rd_ok_next     = rd_ok_reg;
        ptr_next       = ptr_reg;
        post_next      = post_reg;
        pend_next      = state_reg == ST_SCR_COPY;
        pend_addr_next = ptr_reg;
        cell_next      = cell_reg;
        pos_next       = pos_reg;
        col_next       = col_reg;
        lines_next     = lines_reg;
        case (state_reg)
            ST_INIT:
                ptr_next = ptr_last ? '0 : ptr_reg + MAW'(1);
            ST_IDLE:
                if (accept)
                begin
                    code_next    = code;
                    rd_addr_next = rd_lin[MAW-1:0];
                    rd_ok_next   = (32'(row) < 32'(ROWS)) && (32'(col) < 32'(COLS));
                    cell_next    = 8'd0;
                    ptr_next     = '0;
                    post_next    = 1'b0;
                end
            ST_PUT_CHK:
            begin
                ptr_next  = '0;
                post_next = 1'b0;
            end
            ST_POST:
            begin
                ptr_next  = '0;
                post_next = 1'b1;
            end
            ST_PUT_WR, ST_NL_FILL:
            begin
                pos_next = alu_sum;
                if (last_col)
                begin
                    col_next   = '0;
                    lines_next = lines_reg + LW'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
            ST_SCR_COPY, ST_SCR_ZERO:
                ptr_next = ptr_reg + MAW'(1);
            ST_SCR_END:
            begin
                if (lines_reg != '0)
                    lines_next = lines_reg - LW'(1);
                if (pos_reg >= AW'(COLS))
                    pos_next = alu_sum;
                else
                begin
                    pos_next = '0;
                    col_next = '0;
                end
            end
            ST_CLR:
            begin
                ptr_next = ptr_reg + MAW'(1);
                if (ptr_last)
                begin
                    pos_next   = '0;
                    col_next   = '0;
                    lines_next = '0;
                end
            end
            ST_RD_DATA:
                cell_next = rd_ok_reg ? mem_rdata : 8'd0;
            default:
                ptr_next = ptr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            ptr_reg   <= '0;
            pos_reg   <= '0;
            col_reg   <= '0;
            lines_reg <= '0;
            pend_reg  <= 1'b0;
            post_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            pos_reg   <= pos_next;
            col_reg   <= col_next;
            lines_reg <= lines_next;
            pend_reg  <= pend_next;
            post_reg  <= post_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg      <= code_next;
        rd_addr_reg   <= rd_addr_next;
        rd_ok_reg     <= rd_ok_next;
        pend_addr_reg <= pend_addr_next;
        cell_reg      <= cell_next;
    end

    assign res_cell   = cell_reg;
    assign res_cursor = pos_reg;
    assign res_lines  = lines_reg;

endmodule

// ===== hw/rtl/tcw_checker.sv =====
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg for the default geometry.
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  cell_code,
    input logic [10:0] cursor_cell,
    input logic [4:0]  line_count
);

    localparam bit FITS = (ROWS * COLS < 2048) && (ROWS < 32);

    // A stalled result keeps its fields.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_code)
            && $stable(cursor_cell) && $stable(line_count))
        else $error("result changed while stalled");

    // The sequencer leaves idle on every accepted item, so input is closed right after one.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");

    // The count of lines never passes the number of rows.
    a_lines_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && FITS |-> 32'(line_count) <= ROWS)
        else $error("line count above row count");

    // The cursor always sits on the row given by the line count.
    a_cursor_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && FITS |->
            (32'(cursor_cell) >= 32'(line_count) * COLS)
            && (32'(cursor_cell) < (32'(line_count) + 1) * COLS))
        else $error("cursor row and line count disagree");

endmodule

bind text_console_writer tcw_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tcw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cell_code   (cell_code),
    .cursor_cell (cursor_cell),
    .line_count  (line_count)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for text_console_writer, a character-cell screen writer.
// Keeps a mirror of the screen, cursor and line count to predict every result.
// Depends on tcw_pkg for item kinds, character codes and screen geometry.
module tb_top;
    import tcw_pkg::*;

    localparam int SCREEN_ROWS = ROWS_DEF;
    localparam int SCREEN_COLS = COLS_DEF;
    localparam int SCREEN_CELLS = SCREEN_ROWS * SCREEN_COLS;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int IDLE_PCT = 7;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STUCK_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_ITEMS = 1250;
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic [7:0]  cell_code;
        logic [10:0] cursor_cell;
        logic [4:0]  line_count;
    } console_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  kind = KIND_PUT;
    logic [7:0]  code = '0;
    logic [4:0]  row = '0;
    logic [6:0]  col = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  cell_code;
    logic [10:0] cursor_cell;
    logic [4:0]  line_count;

    logic [7:0] screen_mirror [SCREEN_CELLS];
    int cursor_mirror = 0;
    int lines_mirror = 0;

    console_result_t pending_results [$];
    int mismatches = 0;
    int stuck_cycles = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    bit calm = 1'b0;

    text_console_writer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .code       (code),
        .row        (row),
        .col        (col),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_code  (cell_code),
        .cursor_cell(cursor_cell),
        .line_count (line_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void write_mirror(int idx, logic [7:0] value);
        if (idx < SCREEN_CELLS)
            screen_mirror[idx] = value;
    endfunction

    function automatic void scroll_mirror();
        for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
            screen_mirror[i] = screen_mirror[i + SCREEN_COLS];
        for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
            screen_mirror[i] = BLANK_CODE;
        if (lines_mirror > 0)
            lines_mirror--;
        cursor_mirror = (cursor_mirror >= SCREEN_COLS) ? cursor_mirror - SCREEN_COLS : 0;
    endfunction

    function automatic void scroll_while_full();
        while (lines_mirror >= SCREEN_ROWS)
            scroll_mirror();
    endfunction

    // Updates the mirror with one item and returns the result it should produce.
    function automatic console_result_t apply_console_item(logic [1:0] k, logic [7:0] c,
                                                           logic [4:0] r, logic [6:0] cl);
        console_result_t res;
        int fill;
        res.cell_code = BLANK_CODE;
        case (k)
            KIND_PUT:
            begin
                scroll_while_full();
                if (c == NEWLINE_CODE)
                begin
                    fill = SCREEN_COLS - (cursor_mirror % SCREEN_COLS);
                    repeat (fill)
                    begin
                        write_mirror(cursor_mirror, SPACE_CODE);
                        cursor_mirror++;
                    end
                    lines_mirror++;
                end
                else
                begin
                    write_mirror(cursor_mirror, c);
                    cursor_mirror++;
                    if (cursor_mirror % SCREEN_COLS == 0)
                        lines_mirror++;
                    scroll_while_full();
                end
            end
            KIND_READ:
            begin
                if (r < SCREEN_ROWS && cl < SCREEN_COLS)
                    res.cell_code = screen_mirror[r * SCREEN_COLS + cl];
            end
            KIND_CLEAR:
            begin
                foreach (screen_mirror[i])
                    screen_mirror[i] = SPACE_CODE;
                cursor_mirror = 0;
                lines_mirror = 0;
            end
            default: ;
        endcase
        res.cursor_cell = cursor_mirror[10:0];
        res.line_count = lines_mirror[4:0];
        return res;
    endfunction

    task automatic send_item(input logic [1:0] k, input logic [7:0] c,
                             input logic [4:0] r, input logic [6:0] cl);
        if (!calm && $urandom_range(99) < IDLE_PCT)
            repeat ($urandom_range(1, 6)) @(negedge clk) in_valid <= 1'b0;
        @(negedge clk);
        in_valid <= 1'b1;
        kind <= k;
        code <= c;
        row <= r;
        col <= cl;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(apply_console_item(k, c, r, cl));
    endtask

    task automatic wait_for_results();
        @(negedge clk) in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] random_glyph();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == NEWLINE_CODE)
            c = SPACE_CODE;
        return c;
    endfunction

    // The store comes out of reset all zero; reads outside the screen give zero too.
    task automatic test_after_reset();
        send_item(KIND_READ, 8'h00, 5'd0, 7'd0);
        send_item(KIND_READ, 8'hff, 5'(SCREEN_ROWS - 1), 7'(SCREEN_COLS - 1));
        send_item(KIND_READ, 8'h00, 5'(SCREEN_ROWS), 7'd0);
        send_item(KIND_READ, 8'h00, 5'd0, 7'(SCREEN_COLS));
        send_item(KIND_READ, 8'hff, 5'h1f, 7'h7f);
    endtask

    task automatic test_put_cases();
        send_item(KIND_PUT, BLANK_CODE, 5'h1f, 7'h7f);
        send_item(KIND_PUT, 8'hff, 5'd0, 7'd0);
        send_item(KIND_PUT, NEWLINE_CODE, 5'd0, 7'd0);
        send_item(KIND_READ, 8'h00, 5'd0, 7'd1);
        send_item(KIND_READ, 8'h00, 5'd0, 7'(SCREEN_COLS - 1));
        send_item(KIND_READ, 8'h00, 5'd1, 7'd0);
        send_item(KIND_UNUSED, 8'hff, 5'h1f, 7'h7f);
        send_item(KIND_UNUSED, 8'h00, 5'd0, 7'd0);
        send_item(KIND_CLEAR, 8'h00, 5'd0, 7'd0);
        send_item(KIND_READ, 8'h00, 5'(SCREEN_ROWS - 1), 7'(SCREEN_COLS - 1));
        send_item(KIND_PUT, random_glyph(), 5'd0, 7'd0);
    endtask

    // Fill the screen with newlines so the cursor parks past the last cell, then
    // scroll on the next put and again when the last row wraps.
    task automatic test_scroll_paths();
        send_item(KIND_CLEAR, 8'h00, 5'd0, 7'd0);
        repeat (SCREEN_ROWS) send_item(KIND_PUT, NEWLINE_CODE, 5'd0, 7'd0);
        send_item(KIND_READ, 8'h00, 5'(SCREEN_ROWS - 1), 7'(SCREEN_COLS - 1));
        repeat (SCREEN_COLS) send_item(KIND_PUT, random_glyph(), 5'd0, 7'd0);
        send_item(KIND_READ, 8'h00, 5'(SCREEN_ROWS - 2), 7'd5);
        send_item(KIND_READ, 8'h00, 5'(SCREEN_ROWS - 1), 7'd0);
        wait_for_results();
    endtask

    // Receiver holds off while the sender keeps offering, so the block stalls its input.
    task automatic test_stall_fill();
        hold_requests++;
        repeat (20)
            send_item($urandom_range(1) ? KIND_READ : KIND_PUT, random_glyph(),
                      5'($urandom_range(0, SCREEN_ROWS - 1)),
                      7'($urandom_range(0, SCREEN_COLS - 1)));
        wait_for_results();
    endtask

    task automatic test_random_sessions();
        int sent;
        int session;
        int span;
        int nl_pct;
        int pick;
        int sel;
        int last;
        logic [1:0] k;
        logic [7:0] c;
        logic [4:0] r;
        logic [6:0] cl;
        sent = 0;
        session = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm = (session == 4);
            span = $urandom_range(30, 150);
            case ($urandom_range(0, 3))
                0: nl_pct = 0;
                1: nl_pct = 3;
                2: nl_pct = 12;
                default: nl_pct = 35;
            endcase
            if ($urandom_range(99) < 60)
            begin
                send_item(KIND_CLEAR, 8'($urandom_range(0, 255)),
                          5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
                sent++;
            end
            repeat (span)
            begin
                pick = $urandom_range(99);
                c = 8'($urandom_range(0, 255));
                r = 5'($urandom_range(0, 31));
                cl = 7'($urandom_range(0, 127));
                if (pick < 2)
                    k = KIND_UNUSED;
                else if (pick < 3)
                    k = KIND_CLEAR;
                else if (pick < 28)
                begin
                    k = KIND_READ;
                    sel = $urandom_range(99);
                    if (sel < 40 && cursor_mirror > 0)
                    begin
                        last = cursor_mirror - 1;
                        r = 5'(last / SCREEN_COLS);
                        cl = 7'(last % SCREEN_COLS);
                    end
                    else if (sel < 85)
                    begin
                        r = 5'($urandom_range(0, SCREEN_ROWS - 1));
                        cl = 7'($urandom_range(0, SCREEN_COLS - 1));
                    end
                end
                else
                begin
                    k = KIND_PUT;
                    if ($urandom_range(99) < nl_pct)
                        c = NEWLINE_CODE;
                end
                send_item(k, c, r, cl);
                sent++;
            end
            if ($urandom_range(99) < 20)
                wait_for_results();
            session++;
        end
        calm = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (calm)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        console_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: cell %0d cursor %0d lines %0d",
                             cell_code, cursor_cell, line_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (cell_code !== want.cell_code || cursor_cell !== want.cursor_cell ||
                    line_count !== want.line_count)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result differs: cell %0d/%0d cursor %0d/%0d lines %0d/%0d",
                                 want.cell_code, cell_code, want.cursor_cell, cursor_cell,
                                 want.line_count, line_count);
                end
            end
        end
    end

    // Stops the run if neither side moves an item for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("text_console_writer: mismatch");
            $finish;
        end
    end

    initial
    begin
        foreach (screen_mirror[i])
            screen_mirror[i] = BLANK_CODE;
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        test_after_reset();
        test_put_cases();
        test_scroll_paths();
        test_stall_fill();
        test_random_sessions();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("text_console_writer: match");
        else
            $display("text_console_writer: mismatch");
        $finish;
    end

endmodule
